[hw/rtl/ecal_pkg.sv]
// ============================================================================
// ecal_pkg
// Shared types, constants and tables of the epoch-to-calendar pipeline.
// ============================================================================
package ecal_pkg;

    localparam int ZONE_W = 5;
    localparam int EPOCH_W = 32;
    localparam int HOUR_W = 21;
    localparam int REM_W = 12;
    localparam int HOY_W = 14;
    localparam int DAY_W = 9;
    localparam int IN_TDATA_W = 32;
    localparam int OUT_TDATA_W = 40;

    localparam logic [ZONE_W-1:0] ZONE_RESET = 5'd8;

    // reciprocals for division by constants (exact over the ranges used)
    localparam logic [28:0] RECIP_225 = 29'd305419897;   // >> 36
    localparam logic [7:0]  DIV_225 = 8'd225;
    localparam logic [18:0] RECIP_4383 = 19'd489958;     // >> 31
    localparam logic [15:0] HOURS_PER_BLOCK = 16'd35064;
    localparam logic [12:0] RECIP_60 = 13'd4370;         // >> 18
    localparam logic [5:0]  SECS_PER_MIN = 6'd60;
    localparam logic [10:0] RECIP_3 = 11'd1366;          // >> 12
    localparam logic [4:0]  HOURS_PER_DAY = 5'd24;

    // hour offsets of the years in a four-year block starting at 1970
    localparam logic [15:0] YEAR1_START = 16'd8760;
    localparam logic [15:0] YEAR2_START = 16'd17520;
    localparam logic [15:0] YEAR3_START = 16'd26304;
    localparam logic [1:0]  LEAP_YEAR_IDX = 2'd2;
    localparam logic [7:0]  YEAR_BASE = 8'd70;

    localparam logic [DAY_W-1:0] FEB29_DAY = 9'd60;
    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [4:0] DAY_29 = 5'd29;

    typedef logic signed [ZONE_W-1:0] zone_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hours;
        logic [REM_W-1:0]  rem_secs;
    } hour_item_t;

    typedef struct packed {
        logic [7:0]       year;
        logic             leap;
        logic [HOY_W-1:0] hoy;
        logic [5:0]       minute;
        logic [5:0]       second;
    } year_item_t;

    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] dom;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } cal_item_t;

    // first day of year before each month, common year
    function automatic logic [DAY_W-1:0] month_start(input logic [3:0] idx);
        logic [DAY_W-1:0] v;
        unique case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/ecal_hour_split.sv]
// ============================================================================
// ecal_hour_split
// Two stages: seconds to whole hours plus seconds within the hour, zone
// offset applied in hours, negative result clamped to zero.
// ============================================================================
module ecal_hour_split (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [ecal_pkg::EPOCH_W-1:0] epoch,
    input  ecal_pkg::zone_t              zone,
    output logic                         out_valid,
    output ecal_pkg::hour_item_t         out_item
);
    import ecal_pkg::*;

    logic              v1_reg;
    logic [HOUR_W-1:0] q_reg, q_next;
    logic [27:0]       x_reg;
    logic [3:0]        lo_reg;
    logic              v2_reg;
    hour_item_t        item_reg, item_next;

    logic [56:0]        prod;
    logic [28:0]        qm;
    logic [28:0]        rf;
    logic signed [21:0] hs;

    always_comb begin
        prod = 57'(epoch[31:4]) * 57'(RECIP_225);
        q_next = prod[56:36];
    end

    always_comb begin
        qm = 29'(q_reg) * 29'(DIV_225);
        rf = 29'(x_reg) - qm;
        hs = $signed({1'b0, q_reg}) + 22'(zone);
        if (hs[21]) begin
            item_next.hours = '0;
            item_next.rem_secs = '0;
        end else begin
            item_next.hours = hs[HOUR_W-1:0];
            item_next.rem_secs = {rf[7:0], lo_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
            x_reg <= epoch[31:4];
            lo_reg <= epoch[3:0];
            item_reg <= item_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item = item_reg;

endmodule

[hw/rtl/ecal_year_split.sv]
// ============================================================================
// ecal_year_split
// Three stages: hours into four-year blocks and single years, seconds
// within the hour into minute and second.
// ============================================================================
module ecal_year_split (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  ecal_pkg::hour_item_t in_item,
    output logic                 out_valid,
    output ecal_pkg::year_item_t out_item
);
    import ecal_pkg::*;

    logic              v3_reg, v4_reg, v5_reg;
    logic [5:0]        blk_reg, blk_next;
    logic [5:0]        min3_reg, min3_next;
    logic [HOUR_W-1:0] h3_reg;
    logic [REM_W-1:0]  rem3_reg;
    logic [15:0]       rh_reg, rh_next;
    logic [5:0]        blk4_reg;
    logic [5:0]        min4_reg;
    logic [5:0]        sec4_reg, sec4_next;
    year_item_t        item_reg, item_next;

    logic [36:0] pb;
    logic [23:0] pm;
    logic [20:0] bh;
    logic [20:0] rhf;
    logic [11:0] sm;
    logic [11:0] sf;
    logic [1:0]  yi;
    logic [15:0] ystart;
    logic [15:0] hoyf;

    function automatic logic [20:0] blk3_mul(input logic [5:0] b);
        return 21'(b) * 21'(HOURS_PER_BLOCK);
    endfunction

    always_comb begin
        pb = 37'(in_item.hours[HOUR_W-1:3]) * 37'(RECIP_4383);
        blk_next = pb[36:31];
        pm = 24'(in_item.rem_secs) * 24'(RECIP_60);
        min3_next = pm[23:18];
    end

    always_comb begin
        bh = 21'(blk3_mul(blk_reg));
        rhf = h3_reg - bh;
        rh_next = rhf[15:0];
        sm = 12'(min3_reg) * 12'(SECS_PER_MIN);
        sf = rem3_reg - sm;
        sec4_next = sf[5:0];
    end

    always_comb begin
        priority if (rh_reg >= YEAR3_START) begin
            yi = 2'd3;
            ystart = YEAR3_START;
        end else if (rh_reg >= YEAR2_START) begin
            yi = 2'd2;
            ystart = YEAR2_START;
        end else if (rh_reg >= YEAR1_START) begin
            yi = 2'd1;
            ystart = YEAR1_START;
        end else begin
            yi = 2'd0;
            ystart = '0;
        end
        hoyf = rh_reg - ystart;
        item_next.year = YEAR_BASE + {blk4_reg, 2'b00} + 8'(yi);
        item_next.leap = (yi == LEAP_YEAR_IDX);
        item_next.hoy = hoyf[HOY_W-1:0];
        item_next.minute = min4_reg;
        item_next.second = sec4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            blk_reg <= blk_next;
            min3_reg <= min3_next;
            h3_reg <= in_item.hours;
            rem3_reg <= in_item.rem_secs;
            rh_reg <= rh_next;
            blk4_reg <= blk_reg;
            min4_reg <= min3_reg;
            sec4_reg <= sec4_next;
            item_reg <= item_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_item = item_reg;

endmodule

[hw/rtl/ecal_date_split.sv]
// ============================================================================
// ecal_date_split
// Three stages: hour of year into day and hour, leap-day handling, then
// month and day of month from the month table. Last stage is the output.
// ============================================================================
module ecal_date_split (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  ecal_pkg::year_item_t in_item,
    output logic                 out_valid,
    output ecal_pkg::cal_item_t  out_item
);
    import ecal_pkg::*;

    logic             v6_reg, v7_reg, v8_reg;
    year_item_t       y6_reg;
    logic [9:0]       d6_reg, d6_next;
    logic [7:0]       year7_reg;
    logic [5:0]       min7_reg, sec7_reg;
    logic [4:0]       hour7_reg, hour7_next;
    logic [DAY_W-1:0] day7_reg, day7_next;
    logic             feb29_reg, feb29_next;
    cal_item_t        item_reg, item_next;

    logic [21:0]      pd;
    logic [HOY_W-1:0] dm;
    logic [HOY_W-1:0] hf;
    logic [DAY_W-1:0] doy;
    logic [3:0]       mon;
    logic [DAY_W-1:0] domf;

    always_comb begin
        pd = 22'(in_item.hoy[HOY_W-1:3]) * 22'(RECIP_3);
        d6_next = pd[21:12];
    end

    always_comb begin
        dm = 14'(d6_reg) * 14'(HOURS_PER_DAY);
        hf = y6_reg.hoy - dm;
        hour7_next = hf[4:0];
        doy = DAY_W'(d6_reg) + 9'd1;
        feb29_next = y6_reg.leap && (doy == FEB29_DAY);
        if (y6_reg.leap && (doy > FEB29_DAY)) begin
            day7_next = doy - 9'd1;
        end else begin
            day7_next = doy;
        end
    end

    always_comb begin
        mon = '0;
        for (int i = 1; i < 12; i++) begin
            mon = mon + 4'(day7_reg > month_start(4'(i)));
        end
        domf = day7_reg - month_start(mon);
        item_next.year = year7_reg;
        item_next.hour = hour7_reg;
        item_next.minute = min7_reg;
        item_next.second = sec7_reg;
        if (feb29_reg) begin
            item_next.month = MONTH_FEB;
            item_next.dom = DAY_29;
        end else begin
            item_next.month = mon;
            item_next.dom = domf[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= in_valid;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y6_reg <= in_item;
            d6_reg <= d6_next;
            year7_reg <= y6_reg.year;
            min7_reg <= y6_reg.minute;
            sec7_reg <= y6_reg.second;
            hour7_reg <= hour7_next;
            day7_reg <= day7_next;
            feb29_reg <= feb29_next;
            item_reg <= item_next;
        end
    end

    assign out_valid = v8_reg;
    assign out_item = item_reg;

endmodule

[hw/rtl/epoch_seconds_to_calendar_core.sv]
// ============================================================================
// epoch_seconds_to_calendar_core
// Seconds since 1970 plus a whole-hour zone offset to calendar fields.
// ============================================================================
// Usage:
//   s_ channel: one item per handshake, s_tdata[31:0] = epoch seconds.
//   m_ channel: one item per input item, in order, packed calendar fields.
//   cfg channel: cfg_data is the signed zone offset in hours; cfg_ready is
//   always high. Write it only while no item is in flight.
//   Pipeline: eight register stages (two for hours, three for years,
//   three for the date) lie between the input accept and m_tvalid.
//   Throughput: one item per cycle while the receiver does not stall.
//   Receiver stall: while m_tvalid is high and m_tready low, the whole
//   pipeline holds and s_tready drops; nothing is lost or repeated.
//   Reset: clears all stage valid bits and sets the zone offset to +8.
// ============================================================================
module epoch_seconds_to_calendar_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ecal_pkg::IN_TDATA_W-1:0]  s_tdata,   // [31:0] epoch_seconds
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] years_since_1900, [11:8] month_index, [16:12] day_of_month,
    // [21:17] hour_of_day, [27:22] minute_of_hour, [33:28] second_of_minute
    output logic [ecal_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ecal_pkg::ZONE_W-1:0]      cfg_data   // [4:0] zone_offset_hours
);
    import ecal_pkg::*;

    logic [ZONE_W-1:0] zone_reg;
    logic              en;
    logic              hour_valid, year_valid;
    hour_item_t        hour_item;
    year_item_t        year_item;
    cal_item_t         cal_item;

    assign en = m_tready || !m_tvalid;
    assign s_tready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg <= ZONE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            zone_reg <= cfg_data;
        end
    end

    ecal_hour_split u_hour (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .epoch     (s_tdata[EPOCH_W-1:0]),
        .zone      (zone_t'(zone_reg)),
        .out_valid (hour_valid),
        .out_item  (hour_item)
    );

    ecal_year_split u_year (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (hour_valid),
        .in_item   (hour_item),
        .out_valid (year_valid),
        .out_item  (year_item)
    );

    ecal_date_split u_date (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (year_valid),
        .in_item   (year_item),
        .out_valid (m_tvalid),
        .out_item  (cal_item)
    );

    assign m_tdata = {6'b0, cal_item.second, cal_item.minute, cal_item.hour,
                      cal_item.dom, cal_item.month, cal_item.year};

    a_field_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:8] <= 4'd11) && (m_tdata[16:12] != 5'd0) &&
                     (m_tdata[21:17] <= 5'd23) && (m_tdata[27:22] <= 6'd59) &&
                     (m_tdata[33:28] <= 6'd59))
        else $error("calendar field out of range");

    a_leap_day: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[11:8] == MONTH_FEB) && (m_tdata[16:12] == DAY_29))
        |-> (m_tdata[1:0] == 2'b00))
        else $error("February 29 outside a leap year");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule
